// ===== src/lgts_pkg.sv =====
// shared types, constants and defaults for the lda gibbs topic sampler
package lgts_pkg;

    // parameter defaults
    localparam int P_MAX_TOPICS = 128;
    localparam int P_MAX_DOCS   = 4096;
    localparam int P_MAX_WORDS  = 8192;
    localparam int P_COUNT_BITS = 20;

    // fixed field widths
    localparam int DOC_IN_W   = 12;
    localparam int WORD_IN_W  = 13;
    localparam int TOPIC_IN_W = 7;
    localparam int RAND_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;
    localparam int NT_W       = 8;
    localparam int VS_W       = 14;
    localparam int SMOOTH_W   = 20;
    localparam int QUOT_W     = 32;
    localparam int CDF_W      = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_SHIFT = 8;

    // operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_RESAMPLE = 1'b1;

    // register reset values
    localparam logic [NT_W-1:0]     RST_NUM_TOPICS = NT_W'(100);
    localparam logic [VS_W-1:0]     RST_VOCAB_SIZE = VS_W'(8192);
    localparam logic [SMOOTH_W-1:0] RST_ALPHA      = SMOOTH_W'(32768);
    localparam logic [SMOOTH_W-1:0] RST_BETA       = SMOOTH_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_TOPICS = 8'd0,
        REG_VOCAB_SIZE = 8'd1,
        REG_ALPHA      = 8'd2,
        REG_BETA       = 8'd3
    } t_cfg_reg;

    // classified item passed from front to back
    typedef struct packed {
        logic                  op;
        logic [DOC_IN_W-1:0]   doc;
        logic [WORD_IN_W-1:0]  word;
        logic [TOPIC_IN_W-1:0] topic;
        logic [RAND_W-1:0]     rnd;
        logic                  bad;
    } t_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_PREP,
        ST_K_RD,
        ST_K_DIV,
        ST_K_WAIT,
        ST_K_ACC,
        ST_TOSS,
        ST_S_RD,
        ST_S_CMP,
        ST_DONE
    } t_back_state;

endpackage

// ===== src/lgts_ram.sv =====
// generic simple dual port ram with registered read
module lgts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lgts_div.sv =====
// bit serial q16 ratio divider with saturation
module lgts_div import lgts_pkg::*; #(
    parameter int NW = 37,
    parameter int DW = 38
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QUOT_W-1:0] r_sh;
    logic [QUOT_W-1:0] r_quot;

    logic          w_den_zero;
    logic          w_sat;
    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_den_zero = (i_den == '0);
    assign w_sat      = ((DW+FRAC_SHIFT)'(i_num) >= {i_den, FRAC_SHIFT'(0)});
    assign w_trial    = {r_rem, r_sh[QUOT_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});
    assign w_diff     = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_den_zero && !w_sat;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= DW'(i_num >> FRAC_SHIFT);
            r_sh   <= {i_num[FRAC_SHIFT-1:0], FRAC_SHIFT'(0)};
            r_quot <= (w_den_zero || !w_sat) ? '0 : '1;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_sh   <= {r_sh[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== src/lgts_front.sv =====
// input acceptance, index check and two entry item queue
module lgts_front import lgts_pkg::*; #(
    parameter int MAX_TOPICS = P_MAX_TOPICS,
    parameter int MAX_DOCS   = P_MAX_DOCS,
    parameter int MAX_WORDS  = P_MAX_WORDS,
    localparam int TCNT_W = $clog2(MAX_TOPICS + 1),
    localparam int VCNT_W = $clog2(MAX_WORDS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [DOC_IN_W-1:0]   i_doc_index,
    input  logic [WORD_IN_W-1:0]  i_word_index,
    input  logic [TOPIC_IN_W-1:0] i_current_topic,
    input  logic [RAND_W-1:0]     i_random_fraction,
    input  logic [TCNT_W-1:0]     i_eff_t,
    input  logic [VCNT_W-1:0]     i_eff_v,
    input  logic                  i_clearing,
    input  logic                  i_pop,
    output logic                  o_q_valid,
    output t_item                 o_q_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_item w_item;
    logic  w_push;
    logic  w_pop;

    always_comb begin
        w_item.op    = i_operation;
        w_item.doc   = i_doc_index;
        w_item.word  = i_word_index;
        w_item.topic = i_current_topic;
        w_item.rnd   = i_random_fraction;
        w_item.bad   = (32'(i_doc_index) >= 32'(MAX_DOCS))
                    || (32'(i_word_index) >= 32'(i_eff_v))
                    || (32'(i_current_topic) >= 32'(i_eff_t));
    end

    assign o_in_stall = (r_cnt == 2'd2) || i_clearing;
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

endmodule

// ===== src/lgts_back.sv =====
// count tables, weight loop, topic draw and result register
module lgts_back import lgts_pkg::*; #(
    parameter int MAX_TOPICS = P_MAX_TOPICS,
    parameter int MAX_DOCS   = P_MAX_DOCS,
    parameter int MAX_WORDS  = P_MAX_WORDS,
    parameter int COUNT_BITS = P_COUNT_BITS,
    localparam int TCNT_W = $clog2(MAX_TOPICS + 1),
    localparam int VCNT_W = $clog2(MAX_WORDS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    input  logic [TCNT_W-1:0]     i_eff_t,
    input  logic [VCNT_W-1:0]     i_eff_v,
    input  logic [SMOOTH_W-1:0]   i_alpha,
    input  logic [SMOOTH_W-1:0]   i_beta,
    output logic                  o_clearing,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TOPIC_IN_W-1:0] o_new_topic,
    output logic                  o_bad_index
);

    localparam int TOPIC_W   = $clog2(MAX_TOPICS);
    localparam int DOC_W     = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int WORD_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int DT_DEPTH  = MAX_DOCS * MAX_TOPICS;
    localparam int TW_DEPTH  = MAX_TOPICS * MAX_WORDS;
    localparam int DT_AW     = $clog2(DT_DEPTH);
    localparam int TW_AW     = $clog2(TW_DEPTH);
    localparam int CLR_DEPTH = (DT_DEPTH > TW_DEPTH) ? DT_DEPTH : TW_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int NW        = COUNT_BITS + FRAC_SHIFT + 1;
    localparam int TA_W      = TCNT_W + SMOOTH_W;
    localparam int WB_W      = VCNT_W + SMOOTH_W;
    localparam int DW0       = (COUNT_BITS + FRAC_SHIFT > WB_W) ? COUNT_BITS + FRAC_SHIFT : WB_W;
    localparam int DW        = ((DW0 > TA_W) ? DW0 : TA_W) + 1;
    localparam int PROD_W    = 2 * QUOT_W;
    localparam int TOSS_W    = RAND_W + CDF_W;

    function automatic logic [COUNT_BITS-1:0] f_bump(
        input logic [COUNT_BITS-1:0] c,
        input logic                  up
    );
        logic [COUNT_BITS-1:0] res;
        if (up) begin
            res = (c == '1) ? c : c + 1'b1;
        end else begin
            res = (c == '0) ? c : c - 1'b1;
        end
        return res;
    endfunction

    t_back_state r_state, n_state;
    t_item       r_item, n_item;
    logic [TOPIC_W-1:0]    r_topic, n_topic;
    logic                  r_up, n_up;
    logic [COUNT_BITS-1:0] r_dn, n_dn;
    logic [DW-1:0]         r_tden, n_tden;
    logic [WB_W-1:0]       r_wb, n_wb;
    logic [TCNT_W-1:0]     r_k, n_k;
    logic [CDF_W-1:0]      r_sum, n_sum;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [CDF_W-1:0]      r_toss, n_toss;
    logic [CLR_W-1:0]      r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    logic [TOPIC_IN_W-1:0] r_new_topic, n_new_topic;
    logic                  r_bad, n_bad;

    // ram ports
    logic                  dt_we, dn_we, tw_we, tn_we, cdf_we;
    logic [DT_AW-1:0]      dt_raddr, dt_waddr;
    logic [DOC_W-1:0]      dn_raddr, dn_waddr;
    logic [TW_AW-1:0]      tw_raddr, tw_waddr;
    logic [TOPIC_W-1:0]    tn_raddr, tn_waddr;
    logic [COUNT_BITS-1:0] dt_wdata, dn_wdata, tw_wdata, tn_wdata;
    logic [COUNT_BITS-1:0] dt_q, dn_q, tw_q, tn_q;
    logic [CDF_W-1:0]      cdf_q;
    logic [TOPIC_W-1:0]    w_k_topic;
    logic [TOPIC_W-1:0]    w_rd_topic;
    logic [DOC_W-1:0]      w_doc;
    logic [WORD_W-1:0]     w_word;
    logic                  w_clr;

    // weight datapath
    logic                  w_div_start;
    logic [NW-1:0]         w_phi_num, w_th_num;
    logic [DW-1:0]         w_phi_den;
    logic                  w_phi_busy, w_th_busy;
    logic [QUOT_W-1:0]     w_phi, w_th;
    logic [PROD_W-1:0]     w_prod;
    logic [CDF_W-1:0]      w_p;
    logic [CDF_W:0]        w_sum_ext;
    logic [CDF_W-1:0]      w_sum_sat;
    logic [TOSS_W-1:0]     w_toss_prod;
    logic [TA_W-1:0]       w_ta;
    logic [WB_W-1:0]       w_vb;
    logic [TCNT_W-1:0]     w_k_next;
    logic                  w_out_free;

    assign w_k_topic  = r_k[TOPIC_W-1:0];
    assign w_rd_topic = (r_state == ST_K_RD) ? w_k_topic : r_topic;
    assign w_doc      = DOC_W'(r_item.doc);
    assign w_word     = WORD_W'(r_item.word);
    assign w_clr      = (r_state == ST_CLEAR);

    assign dt_raddr = DT_AW'(DT_AW'(w_doc) * DT_AW'(MAX_TOPICS) + DT_AW'(w_rd_topic));
    assign dn_raddr = w_doc;
    assign tw_raddr = TW_AW'(TW_AW'(w_rd_topic) * TW_AW'(MAX_WORDS) + TW_AW'(w_word));
    assign tn_raddr = w_rd_topic;

    // writes go to the address just read, or sweep during the clearing pass
    assign dt_waddr = w_clr ? DT_AW'(r_clr) : dt_raddr;
    assign dn_waddr = w_clr ? DOC_W'(r_clr) : dn_raddr;
    assign tw_waddr = w_clr ? TW_AW'(r_clr) : tw_raddr;
    assign tn_waddr = w_clr ? TOPIC_W'(r_clr) : tn_raddr;

    assign dt_we = w_clr ? (32'(r_clr) < 32'(DT_DEPTH))   : (r_state == ST_CNT_WR);
    assign dn_we = w_clr ? (32'(r_clr) < 32'(MAX_DOCS))   : (r_state == ST_CNT_WR);
    assign tw_we = w_clr ? (32'(r_clr) < 32'(TW_DEPTH))   : (r_state == ST_CNT_WR);
    assign tn_we = w_clr ? (32'(r_clr) < 32'(MAX_TOPICS)) : (r_state == ST_CNT_WR);

    assign dt_wdata = w_clr ? '0 : f_bump(dt_q, r_up);
    assign dn_wdata = w_clr ? '0 : f_bump(dn_q, r_up);
    assign tw_wdata = w_clr ? '0 : f_bump(tw_q, r_up);
    assign tn_wdata = w_clr ? '0 : f_bump(tn_q, r_up);

    assign cdf_we = (r_state == ST_K_ACC);

    lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(DT_DEPTH)) u_dt_ram (
        .i_clk(i_clk), .i_we(dt_we), .i_waddr(dt_waddr), .i_wdata(dt_wdata),
        .i_raddr(dt_raddr), .o_rdata(dt_q)
    );

    lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_DOCS)) u_dn_ram (
        .i_clk(i_clk), .i_we(dn_we), .i_waddr(dn_waddr), .i_wdata(dn_wdata),
        .i_raddr(dn_raddr), .o_rdata(dn_q)
    );

    lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(TW_DEPTH)) u_tw_ram (
        .i_clk(i_clk), .i_we(tw_we), .i_waddr(tw_waddr), .i_wdata(tw_wdata),
        .i_raddr(tw_raddr), .o_rdata(tw_q)
    );

    lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_TOPICS)) u_tn_ram (
        .i_clk(i_clk), .i_we(tn_we), .i_waddr(tn_waddr), .i_wdata(tn_wdata),
        .i_raddr(tn_raddr), .o_rdata(tn_q)
    );

    lgts_ram #(.WIDTH(CDF_W), .DEPTH(MAX_TOPICS)) u_cdf_ram (
        .i_clk(i_clk), .i_we(cdf_we), .i_waddr(w_k_topic), .i_wdata(w_sum_sat),
        .i_raddr(w_k_topic), .o_rdata(cdf_q)
    );

    // phi and theta ratios run side by side
    assign w_div_start = (r_state == ST_K_DIV);
    assign w_phi_num   = (NW'(tw_q) << FRAC_SHIFT) + NW'(i_beta);
    assign w_phi_den   = (DW'(tn_q) << FRAC_SHIFT) + DW'(r_wb);
    assign w_th_num    = (NW'(dt_q) << FRAC_SHIFT) + NW'(i_alpha);

    lgts_div #(.NW(NW), .DW(DW)) u_phi_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_phi_num), .i_den(w_phi_den), .o_busy(w_phi_busy), .o_quot(w_phi)
    );

    lgts_div #(.NW(NW), .DW(DW)) u_th_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_th_num), .i_den(r_tden), .o_busy(w_th_busy), .o_quot(w_th)
    );

    assign w_prod      = w_phi * w_th;
    assign w_p         = (|r_prod[PROD_W-1:CDF_W+PROD_SHIFT]) ? '1
                       : r_prod[CDF_W+PROD_SHIFT-1:PROD_SHIFT];
    assign w_sum_ext   = {1'b0, r_sum} + {1'b0, w_p};
    assign w_sum_sat   = w_sum_ext[CDF_W] ? '1 : w_sum_ext[CDF_W-1:0];
    assign w_toss_prod = r_item.rnd * r_sum;
    assign w_ta        = TA_W'(i_eff_t) * TA_W'(i_alpha);
    assign w_vb        = WB_W'(i_eff_v) * WB_W'(i_beta);
    assign w_k_next    = r_k + 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_topic     = r_topic;
        n_up        = r_up;
        n_dn        = r_dn;
        n_tden      = r_tden;
        n_wb        = r_wb;
        n_k         = r_k;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_toss      = r_toss;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_new_topic = r_new_topic;
        n_bad       = r_bad;
        o_q_pop     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == CLR_DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_topic = TOPIC_W'(i_q_item.topic);
                    n_up    = (i_q_item.op == OP_LOAD);
                    n_state = i_q_item.bad ? ST_DONE : ST_CNT_RD;
                end
            end
            ST_CNT_RD: begin
                n_state = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                n_dn    = dn_wdata;
                n_state = r_up ? ST_DONE : ST_PREP;
            end
            ST_PREP: begin
                n_tden  = (DW'(r_dn) << FRAC_SHIFT) + DW'(w_ta);
                n_wb    = w_vb;
                n_k     = '0;
                n_sum   = '0;
                n_state = ST_K_RD;
            end
            ST_K_RD: begin
                n_state = ST_K_DIV;
            end
            ST_K_DIV: begin
                n_state = ST_K_WAIT;
            end
            ST_K_WAIT: begin
                if (!w_phi_busy && !w_th_busy) begin
                    n_prod  = w_prod;
                    n_state = ST_K_ACC;
                end
            end
            ST_K_ACC: begin
                n_sum = w_sum_sat;
                if (w_k_next == i_eff_t) begin
                    n_state = ST_TOSS;
                end else begin
                    n_k     = w_k_next;
                    n_state = ST_K_RD;
                end
            end
            ST_TOSS: begin
                n_toss  = w_toss_prod[TOSS_W-1:FRAC_SHIFT];
                n_k     = '0;
                n_state = ST_S_RD;
            end
            ST_S_RD: begin
                n_state = ST_S_CMP;
            end
            ST_S_CMP: begin
                if ((w_k_next < i_eff_t) && (cdf_q < r_toss)) begin
                    n_k     = w_k_next;
                    n_state = ST_S_RD;
                end else begin
                    n_topic = w_k_topic;
                    n_up    = 1'b1;
                    n_state = ST_CNT_RD;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_new_topic = r_item.bad ? r_item.topic : TOPIC_IN_W'(r_topic);
                    n_bad       = r_item.bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_topic     <= n_topic;
        r_up        <= n_up;
        r_dn        <= n_dn;
        r_tden      <= n_tden;
        r_wb        <= n_wb;
        r_k         <= n_k;
        r_sum       <= n_sum;
        r_prod      <= n_prod;
        r_toss      <= n_toss;
        r_new_topic <= n_new_topic;
        r_bad       <= n_bad;
    end

    assign o_clearing  = w_clr;
    assign o_out_valid = r_out_valid;
    assign o_new_topic = r_new_topic;
    assign o_bad_index = r_bad;

endmodule

// ===== src/lda_gibbs_topic_sampler.sv =====
// top level of the lda collapsed gibbs topic sampler
//
// input channel: i_in_valid / o_in_stall with operation, doc, word, current topic
// and a 16-bit random fraction; an item is taken on a clock edge with valid high
// and stall low. output channel: o_out_valid / i_out_stall with new_topic and
// bad_index, one result per item, in order.
// config channel: i_cfg_valid / o_cfg_ready (always ready) with register index
// and data; write only while no item is in flight.
// a two entry queue sits between the front (accept, index check) and the back
// (count tables, weight loop, draw), so items are taken while a result waits.
// a resample runs the two bit-serial q16 dividers side by side for every active
// topic, with a count read before them and an accumulate step after them, and
// then scans the cdf memory linearly; a bad item or a load skips both steps.
// items are worked one at a time in the back.
// reset: synchronous, active low; config returns to its defaults and the count
// memories are swept to zero, one entry per cycle, over
// max(MAX_DOCS*MAX_TOPICS, MAX_TOPICS*MAX_WORDS) addresses (1048576 by default),
// with o_in_stall held high; config writes are still taken.
// a stalled output holds its result; the back waits, and the queue then fills
// and raises o_in_stall.
module lda_gibbs_topic_sampler import lgts_pkg::*; #(
    parameter int MAX_TOPICS = P_MAX_TOPICS,
    parameter int MAX_DOCS   = P_MAX_DOCS,
    parameter int MAX_WORDS  = P_MAX_WORDS,
    parameter int COUNT_BITS = P_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [DOC_IN_W-1:0]   i_doc_index,
    input  logic [WORD_IN_W-1:0]  i_word_index,
    input  logic [TOPIC_IN_W-1:0] i_current_topic,
    input  logic [RAND_W-1:0]     i_random_fraction,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TOPIC_IN_W-1:0] o_new_topic,
    output logic                  o_bad_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TCNT_W = $clog2(MAX_TOPICS + 1);
    localparam int VCNT_W = $clog2(MAX_WORDS + 1);

    // config registers
    logic [NT_W-1:0]     r_num_topics;
    logic [VS_W-1:0]     r_vocab_size;
    logic [SMOOTH_W-1:0] r_alpha;
    logic [SMOOTH_W-1:0] r_beta;

    logic [31:0]       w_nt32;
    logic [31:0]       w_vs32;
    logic [TCNT_W-1:0] w_eff_t;
    logic [VCNT_W-1:0] w_eff_v;

    logic  w_clearing;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_topics <= RST_NUM_TOPICS;
            r_vocab_size <= RST_VOCAB_SIZE;
            r_alpha      <= RST_ALPHA;
            r_beta       <= RST_BETA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_NUM_TOPICS: r_num_topics <= i_cfg_data[NT_W-1:0];
                REG_VOCAB_SIZE: r_vocab_size <= i_cfg_data[VS_W-1:0];
                REG_ALPHA:      r_alpha      <= i_cfg_data[SMOOTH_W-1:0];
                REG_BETA:       r_beta       <= i_cfg_data[SMOOTH_W-1:0];
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // zero acts as one, values above the build limit are clamped
    assign w_nt32  = 32'(r_num_topics);
    assign w_vs32  = 32'(r_vocab_size);
    assign w_eff_t = TCNT_W'((w_nt32 == 32'd0) ? 32'd1
                   : (w_nt32 > 32'(MAX_TOPICS)) ? 32'(MAX_TOPICS) : w_nt32);
    assign w_eff_v = VCNT_W'((w_vs32 == 32'd0) ? 32'd1
                   : (w_vs32 > 32'(MAX_WORDS)) ? 32'(MAX_WORDS) : w_vs32);

    lgts_front #(
        .MAX_TOPICS(MAX_TOPICS), .MAX_DOCS(MAX_DOCS), .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_doc_index       (i_doc_index),
        .i_word_index      (i_word_index),
        .i_current_topic   (i_current_topic),
        .i_random_fraction (i_random_fraction),
        .i_eff_t           (w_eff_t),
        .i_eff_v           (w_eff_v),
        .i_clearing        (w_clearing),
        .i_pop             (w_pop),
        .o_q_valid         (w_q_valid),
        .o_q_item          (w_q_item)
    );

    lgts_back #(
        .MAX_TOPICS(MAX_TOPICS), .MAX_DOCS(MAX_DOCS), .MAX_WORDS(MAX_WORDS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_pop),
        .i_eff_t     (w_eff_t),
        .i_eff_v     (w_eff_v),
        .i_alpha     (r_alpha),
        .i_beta      (r_beta),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_new_topic (o_new_topic),
        .o_bad_index (o_bad_index)
    );

    // no item gets in while the count memories are being swept
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("item accepted during clearing pass");

    // a drawn topic always lies within the active topic range
    a_topic_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_bad_index) |-> (32'(o_new_topic) < 32'(w_eff_t)))
        else $error("result topic outside active range");

    // the queue is only popped when it holds an item
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule

// ===== bench/tb_lda_gibbs_topic_sampler.sv =====
// self-checking testbench for the lda gibbs topic sampler: count-table predictor and result checker
`timescale 1ns / 1ps

module tb_lda_gibbs_topic_sampler;
    import lgts_pkg::*;

    localparam int NTOP = P_MAX_TOPICS;
    localparam int NWRD = P_MAX_WORDS;
    localparam int CNT_MAX = (1 << P_COUNT_BITS) - 1;
    localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
    // sweep of the count memories after reset plus a generous margin for the items
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int TOKEN_POOL = 64;

    typedef struct {
        logic                  op;
        logic [DOC_IN_W-1:0]   doc;
        logic [WORD_IN_W-1:0]  word;
        logic [TOPIC_IN_W-1:0] topic;
        logic [RAND_W-1:0]     rnd;
    } t_token_item;

    typedef struct {
        logic [TOPIC_IN_W-1:0] topic;
        logic                  bad;
    } t_draw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_operation;
    logic [DOC_IN_W-1:0]   i_doc_index;
    logic [WORD_IN_W-1:0]  i_word_index;
    logic [TOPIC_IN_W-1:0] i_current_topic;
    logic [RAND_W-1:0]     i_random_fraction;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [TOPIC_IN_W-1:0] o_new_topic;
    logic                  o_bad_index;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lda_gibbs_topic_sampler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_doc_index      (i_doc_index),
        .i_word_index     (i_word_index),
        .i_current_topic  (i_current_topic),
        .i_random_fraction(i_random_fraction),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_new_topic      (o_new_topic),
        .o_bad_index      (o_bad_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // shadow registers and count tables of the sampler
    logic [NT_W-1:0]     topics_reg;
    logic [VS_W-1:0]     vocab_reg;
    logic [SMOOTH_W-1:0] alpha_reg;
    logic [SMOOTH_W-1:0] beta_reg;
    int unsigned doc_topic_cnt[int];
    int unsigned word_topic_cnt[int];
    int unsigned doc_cnt[P_MAX_DOCS];
    int unsigned topic_cnt[NTOP];

    t_draw       pending_draws[$];
    t_token_item live_tokens[$];
    int          mismatches;
    int          results_seen;
    int          loads_sent;
    int          resamples_sent;
    int          bad_seen;
    bit          quiet;
    longint      cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on total run length
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_draws.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned dt_get(int key);
        return doc_topic_cnt.exists(key) ? doc_topic_cnt[key] : 0;
    endfunction

    function automatic int unsigned tw_get(int key);
        return word_topic_cnt.exists(key) ? word_topic_cnt[key] : 0;
    endfunction

    function automatic int unsigned cnt_step(int unsigned c, bit up);
        if (up) return (c < CNT_MAX) ? c + 1 : c;
        return (c > 0) ? c - 1 : c;
    endfunction

    function automatic void touch_token(int d, int z, int w, bit up);
        doc_topic_cnt[d * NTOP + z] = cnt_step(dt_get(d * NTOP + z), up);
        word_topic_cnt[z * NWRD + w] = cnt_step(tw_get(z * NWRD + w), up);
        doc_cnt[d] = cnt_step(doc_cnt[d], up);
        topic_cnt[z] = cnt_step(topic_cnt[z], up);
    endfunction

    // floor(num * 2^16 / den) saturated to 32 bits, zero for a zero denominator
    function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
        if (den == 0) return 0;
        if (num / den >= 65536) return SAT32;
        return (num << 16) / den;
    endfunction

    function automatic int active_topics();
        if (topics_reg == 0) return 1;
        return (topics_reg > NTOP) ? NTOP : int'(topics_reg);
    endfunction

    function automatic int active_vocab();
        if (vocab_reg == 0) return 1;
        return (vocab_reg > NWRD) ? NWRD : int'(vocab_reg);
    endfunction

    // apply one item to the count tables and work out the topic it ends on
    function automatic t_draw gibbs_draw(t_token_item it);
        int t_act;
        int v_act;
        int k;
        longint unsigned tden;
        longint unsigned wb;
        longint unsigned sum;
        longint unsigned toss;
        longint unsigned phi;
        longint unsigned th;
        longint unsigned p;
        longint unsigned cdf[NTOP];
        t_draw r;
        t_act = active_topics();
        v_act = active_vocab();
        r.topic = it.topic;
        r.bad = 1'b0;
        if (it.word >= v_act || it.topic >= t_act) begin
            r.bad = 1'b1;
            return r;
        end
        if (it.op == OP_LOAD) begin
            touch_token(it.doc, it.topic, it.word, 1'b1);
            return r;
        end
        touch_token(it.doc, it.topic, it.word, 1'b0);
        tden = (longint'(doc_cnt[it.doc]) << 16) + longint'(t_act) * alpha_reg;
        wb = longint'(v_act) * beta_reg;
        sum = 0;
        for (k = 0; k < t_act; k++) begin
            phi = q16_ratio((longint'(tw_get(k * NWRD + it.word)) << 16) + beta_reg,
                            (longint'(topic_cnt[k]) << 16) + wb);
            th = q16_ratio((longint'(dt_get(it.doc * NTOP + k)) << 16) + alpha_reg, tden);
            p = (phi * th) >> 8;
            if (p > SAT32) p = SAT32;
            sum += p;
            if (sum > SAT32) sum = SAT32;
            cdf[k] = sum;
        end
        toss = (longint'(it.rnd) * sum) >> 16;
        k = 0;
        while (k + 1 < t_act && cdf[k] < toss) k++;
        touch_token(it.doc, k, it.word, 1'b1);
        r.topic = k[TOPIC_IN_W-1:0];
        return r;
    endfunction

    // output stall: random bursts unless the quiet stretch is on
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare every taken result with the oldest expected draw
    always @(posedge i_clk) begin
        t_draw exp_d;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (pending_draws.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result topic=%0d bad=%0b", o_new_topic, o_bad_index);
            end else begin
                exp_d = pending_draws.pop_front();
                if (exp_d.topic !== o_new_topic || exp_d.bad !== o_bad_index) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result %0d: expected topic=%0d bad=%0b, got topic=%0d bad=%0b",
                                 results_seen, exp_d.topic, exp_d.bad, o_new_topic,
                                 o_bad_index);
                end
                if (exp_d.bad) bad_seen <= bad_seen + 1;
            end
        end
    end

    // predict, then hold the item on the port until it is taken
    task automatic send_item(t_token_item it);
        t_draw d;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        d = gibbs_draw(it);
        pending_draws.insert(pending_draws.size(), d);
        if (it.op == OP_LOAD) loads_sent++;
        else resamples_sent++;
        i_in_valid        <= 1'b1;
        i_operation       <= it.op;
        i_doc_index       <= it.doc;
        i_word_index      <= it.word;
        i_current_topic   <= it.topic;
        i_random_fraction <= it.rnd;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_fields(logic op, int doc, int word, int topic, int rnd);
        t_token_item it;
        it.op = op;
        it.doc = DOC_IN_W'(doc);
        it.word = WORD_IN_W'(word);
        it.topic = TOPIC_IN_W'(topic);
        it.rnd = RAND_W'(rnd);
        send_item(it);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_NUM_TOPICS: topics_reg = val[NT_W-1:0];
            REG_VOCAB_SIZE: vocab_reg = val[VS_W-1:0];
            REG_ALPHA:      alpha_reg = val;
            REG_BETA:       beta_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // let every expected result drain before touching the registers
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(int nt, int vs, int alpha, int beta);
        wait_drained();
        write_reg(REG_NUM_TOPICS, CFG_DATA_W'(nt));
        write_reg(REG_VOCAB_SIZE, CFG_DATA_W'(vs));
        write_reg(REG_ALPHA, CFG_DATA_W'(alpha));
        write_reg(REG_BETA, CFG_DATA_W'(beta));
    endtask

    // extremes of every field under the reset configuration
    task automatic test_field_extremes();
        send_fields(OP_LOAD, 0, 0, 0, 0);
        send_fields(OP_LOAD, 4095, 8191, 99, 0);
        send_fields(OP_LOAD, 4095, 0, 99, 65535);
        send_fields(OP_LOAD, 0, 8191, 0, 0);
        send_fields(OP_RESAMPLE, 4095, 8191, 99, 65535);
        send_fields(OP_RESAMPLE, 0, 0, 0, 0);
        // topic beyond the active count is flagged and ignored
        send_fields(OP_LOAD, 12, 40, 127, 0);
        send_fields(OP_RESAMPLE, 12, 40, 100, 1234);
        // token that was never loaded: decrements stop at zero
        send_fields(OP_RESAMPLE, 7, 5, 3, 40000);
    endtask

    // clamping of out-of-range register values and an unknown register
    task automatic test_register_limits();
        set_config(0, 0, 32768, 655);
        send_fields(OP_LOAD, 3, 0, 0, 0);
        send_fields(OP_LOAD, 3, 1, 0, 0);
        send_fields(OP_RESAMPLE, 3, 0, 0, 50000);
        set_config(255, 16383, 20'hFFFFF, 20'hFFFFF);
        send_fields(OP_LOAD, 1, 8191, 127, 0);
        send_fields(OP_RESAMPLE, 1, 8191, 127, 65535);
        wait_drained();
        write_reg(t_cfg_reg'(8'd200), 20'h00005);
        send_fields(OP_RESAMPLE, 1, 8191, 5, 30000);
    endtask

    // zero alpha and beta give zero denominators and an all-zero total
    task automatic test_zero_smoothing();
        set_config(4, 64, 0, 0);
        send_fields(OP_LOAD, 3000, 10, 2, 0);
        send_fields(OP_RESAMPLE, 3000, 10, 2, 65535);
        send_fields(OP_RESAMPLE, 3001, 11, 3, 12345);
        send_fields(OP_LOAD, 3002, 10, 3, 0);
        send_fields(OP_RESAMPLE, 3002, 10, 3, 65535);
    endtask

    // mostly well-formed load and resample traffic on a small pool of documents and words
    task automatic test_random_traffic(int n);
        t_token_item it;
        int t_act;
        int v_act;
        int sel;
        int idx;
        t_draw d;
        t_act = active_topics();
        v_act = active_vocab();
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            it.rnd = RAND_W'($urandom());
            if (sel < 10) begin
                // noise: every field fully random
                it.op = 1'($urandom());
                it.doc = DOC_IN_W'($urandom());
                it.word = WORD_IN_W'($urandom());
                it.topic = TOPIC_IN_W'($urandom());
            end else if (sel < 55 || live_tokens.size() == 0) begin
                it.op = OP_LOAD;
                it.doc = DOC_IN_W'(($urandom_range(0, 9) == 0) ? 4095 - $urandom_range(0, 3)
                                                               : $urandom_range(0, 7));
                it.word = WORD_IN_W'(($urandom_range(0, 9) == 0) ? v_act - 1
                                                                 : $urandom_range(0, 15) % v_act);
                it.topic = TOPIC_IN_W'($urandom_range(0, t_act - 1));
            end else begin
                idx = $urandom_range(0, live_tokens.size() - 1);
                it = live_tokens[idx];
                it.op = OP_RESAMPLE;
                it.rnd = RAND_W'($urandom());
            end
            // track where each token sits now so later resamples stay well-formed
            if (it.op == OP_RESAMPLE && sel >= 10) begin
                send_item(it);
                d = pending_draws[$];
                it.topic = d.topic;
                live_tokens[idx] = it;
            end else begin
                send_item(it);
                if (it.op == OP_LOAD && sel >= 10) begin
                    if (live_tokens.size() < TOKEN_POOL)
                        live_tokens.insert(live_tokens.size(), it);
                    else live_tokens[$urandom_range(0, TOKEN_POOL - 1)] = it;
                end
            end
        end
    endtask

    task automatic test_random_settings();
        set_config(8, 64, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF));
        test_random_traffic(400);
        set_config(2, 1000, 32768, 655);
        test_random_traffic(400);
        set_config(16, 8192, $urandom_range(0, 65535), $urandom_range(0, 4095));
        test_random_traffic(350);
        set_config(5, 32, 1, 1);
        test_random_traffic(400);
        set_config(128, 8192, 512, 655);
        test_random_traffic(20);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        set_config(4, 16, 6554, 3277);
        quiet = 1'b1;
        test_random_traffic(250);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_LOAD;
        i_doc_index       <= '0;
        i_word_index      <= '0;
        i_current_topic   <= '0;
        i_random_fraction <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= REG_NUM_TOPICS;
        i_cfg_data        <= '0;
        quiet = 1'b0;
        mismatches = 0;
        results_seen = 0;
        loads_sent = 0;
        resamples_sent = 0;
        bad_seen = 0;
        topics_reg = RST_NUM_TOPICS;
        vocab_reg = RST_VOCAB_SIZE;
        alpha_reg = RST_ALPHA;
        beta_reg = RST_BETA;
        for (int i = 0; i < P_MAX_DOCS; i++) doc_cnt[i] = 0;
        for (int i = 0; i < NTOP; i++) topic_cnt[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_register_limits();
        test_zero_smoothing();
        test_random_settings();
        test_full_rate();

        wait_drained();
        $display("items sent: %0d loads, %0d resamples; %0d results checked, %0d flagged bad",
                 loads_sent, resamples_sent, results_seen, bad_seen);
        $display("covered topic counts 1 to 128, vocab clamping, zero smoothing, out/in stalls");
        if (mismatches == 0 && pending_draws.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
